// ----- rtl/core/clss_pkg.sv -----
// Shared types and codes for the cyclic load-step sequencer.
// Used by clss_cfg, clss_core and cyclic_load_step_sequencer; depends on nothing.
package clss_pkg;

    // Item kinds on the input stream.
    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_STOP  = 3'd1;
    localparam logic [2:0] MODE_FORCE = 3'd2;
    localparam logic [2:0] MODE_DIST  = 3'd3;
    localparam logic [2:0] MODE_TICK  = 3'd4;

    // Motor commands.
    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_FWD  = 3'd1;
    localparam logic [2:0] CMD_BACK = 3'd2;
    localparam logic [2:0] CMD_STOP = 3'd3;
    localparam logic [2:0] CMD_GOTO = 3'd4;

    // Speed commands.
    localparam logic [1:0] SPD_KEEP    = 2'd0;
    localparam logic [1:0] SPD_NORMAL  = 2'd1;
    localparam logic [1:0] SPD_REDUCED = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_CONTROL_MODE  = 3'd0;
    localparam logic [2:0] REG_TARGET_LIMIT  = 3'd1;
    localparam logic [2:0] REG_START_LENGTH  = 3'd2;
    localparam logic [2:0] REG_END_POSITION  = 3'd3;
    localparam logic [2:0] REG_CYCLE_COUNT   = 3'd4;
    localparam logic [2:0] REG_DISTANCE_BAND = 3'd5;
    localparam logic [2:0] REG_FORCE_BAND    = 3'd6;
    localparam logic [2:0] REG_HOLD_TIMES    = 3'd7;

    // Phase codes as they appear on the result stream.
    localparam logic [2:0] PHASE_IDLE  = 3'd0;
    localparam logic [2:0] PHASE_START = 3'd4;
    localparam logic [2:0] PHASE_END   = 3'd5;

    // Configuration register set.
    typedef struct packed {
        logic [1:0]         control_mode;
        logic signed [31:0] target_limit;
        logic signed [31:0] start_length;
        logic signed [31:0] end_position;
        logic [15:0]        cycle_count;
        logic [15:0]        distance_band;
        logic [15:0]        force_band;
        logic [31:0]        hold_times;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [2:0]         motor_cmd;
        logic [1:0]         speed_cmd;
        logic signed [31:0] goto_position;
        logic [2:0]         phase;
        logic [15:0]        cycle_index;
        logic               finished;
    } t_result;

endpackage

// ----- rtl/core/clss_cfg.sv -----
// Configuration register file for the cyclic load-step sequencer.
// Depends on clss_pkg for the register set type and register indexes.
module clss_cfg
    import clss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Decode one register write.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CONTROL_MODE:  n_cfg.control_mode  = i_cfg_data[1:0];
                REG_TARGET_LIMIT:  n_cfg.target_limit  = $signed(i_cfg_data);
                REG_START_LENGTH:  n_cfg.start_length  = $signed(i_cfg_data);
                REG_END_POSITION:  n_cfg.end_position  = $signed(i_cfg_data);
                REG_CYCLE_COUNT:   n_cfg.cycle_count   = i_cfg_data[15:0];
                REG_DISTANCE_BAND: n_cfg.distance_band = i_cfg_data[15:0];
                REG_FORCE_BAND:    n_cfg.force_band    = i_cfg_data[15:0];
                REG_HOLD_TIMES:    n_cfg.hold_times    = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    // Register set with its reset values; the cycle count resets to one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.control_mode  <= 2'd0;
            r_cfg.target_limit  <= 32'sd0;
            r_cfg.start_length  <= 32'sd0;
            r_cfg.end_position  <= 32'sd0;
            r_cfg.cycle_count   <= 16'd1;
            r_cfg.distance_band <= 16'd0;
            r_cfg.force_band    <= 16'd0;
            r_cfg.hold_times    <= 32'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/clss_core.sv -----
// Sequencer state and the single-pass evaluation of one item.
// Depends on clss_pkg for codes, the register set and the result type.
module clss_core
    import clss_pkg::*;
#(
    parameter int SLOW_ZONE_FACTOR = 200,
    parameter int TIMER_WIDTH      = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_sample,
    input  t_cfg               i_cfg,
    output t_result            o_res
);

    localparam int SZ_W = $clog2(SLOW_ZONE_FACTOR + 1);
    localparam int ZW   = 16 + SZ_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_DELAY = 3'd1,
        ST_RUN   = 3'd2,
        ST_DWELL = 3'd3,
        ST_START = 3'd4,
        ST_END   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } t_dir;

    t_phase                   r_phase, n_phase;
    t_dir                     r_dir, n_dir;
    logic signed [31:0]       r_active, n_active;
    logic [15:0]              r_cnt, n_cnt;
    logic [TIMER_WIDTH-1:0]   r_timer, n_timer;
    logic                     r_slow, n_slow;
    logic                     r_track, n_track;
    logic signed [31:0]       r_last_force, n_last_force;
    logic signed [31:0]       r_last_dist, n_last_dist;

    logic                     by_force;
    logic signed [31:0]       run_value;
    logic signed [31:0]       run_target;
    logic signed [32:0]       run_diff;
    logic [32:0]              run_mag;
    logic [15:0]              run_band;
    logic signed [32:0]       band_s;
    logic                     above_band;
    logic                     below_band;
    logic [ZW-1:0]            zone;
    logic                     in_zone;
    logic signed [32:0]       start_diff;
    logic [32:0]              start_mag;
    logic                     near_start;
    logic signed [32:0]       end_diff;
    logic [32:0]              end_mag;
    logic [36:0]              end_lhs;
    logic [18:0]              end_rhs;
    logic                     near_end;
    logic [TIMER_WIDTH-1:0]   delay_load;
    logic [TIMER_WIDTH-1:0]   dwell_load;
    logic                     delay_zero;
    logic                     dwell_zero;
    logic                     last_cycle;
    t_result                  res;

    // Run rule inputs. The sample being delivered is the value of its own kind.
    // Already in run the stored active target applies; an item that enters run
    // takes the configured limit, which becomes the active target.
    assign by_force   = i_cfg.control_mode[0];
    assign run_value  = by_force ? ((i_mode == MODE_FORCE) ? i_sample : r_last_force)
                                 : ((i_mode == MODE_DIST)  ? i_sample : r_last_dist);
    assign run_target = (r_phase == ST_RUN) ? r_active : i_cfg.target_limit;
    assign run_diff   = 33'(run_value) - 33'(run_target);
    assign run_mag    = run_diff[32] ? 33'(-run_diff) : 33'(run_diff);
    assign run_band   = by_force ? i_cfg.force_band : i_cfg.distance_band;
    assign band_s     = $signed({17'd0, run_band});
    assign above_band = run_diff > band_s;
    assign below_band = run_diff < -band_s;

    // Slow zone around the distance limit.
    assign zone    = ZW'(SLOW_ZONE_FACTOR) * ZW'(i_cfg.distance_band);
    assign in_zone = run_mag < 33'(zone);

    // Arrival back at the start length: twice the distance under the band.
    assign start_diff = 33'(i_cfg.start_length) - 33'(i_sample);
    assign start_mag  = start_diff[32] ? 33'(-start_diff) : 33'(start_diff);
    assign near_start = {start_mag, 1'b0} < {18'd0, i_cfg.distance_band};

    // Arrival at the end position: ten times the distance under seven bands.
    assign end_diff = 33'(r_active) - 33'(i_sample);
    assign end_mag  = end_diff[32] ? 33'(-end_diff) : 33'(end_diff);
    assign end_lhs  = {1'b0, end_mag, 3'b000} + {3'b000, end_mag, 1'b0};
    assign end_rhs  = {i_cfg.distance_band, 3'b000} - {3'b000, i_cfg.distance_band};
    assign near_end = end_lhs < {18'd0, end_rhs};

    // Hold loads, truncated or widened to the timer.
    assign delay_zero = (i_cfg.hold_times[15:0] == 16'd0);
    assign dwell_zero = (i_cfg.hold_times[31:16] == 16'd0);
    assign delay_load = TIMER_WIDTH'({16'd0, i_cfg.hold_times[15:0]});
    assign dwell_load = TIMER_WIDTH'({16'd0, i_cfg.hold_times[31:16]});

    // Next state and result of one item.
    always_comb begin
        logic do_begin;
        logic stop_motor;
        logic do_enter;
        logic do_eval;
        logic do_reach;
        logic do_after;

        do_begin   = 1'b0;
        stop_motor = 1'b0;
        do_enter   = 1'b0;
        do_eval    = 1'b0;
        do_reach   = 1'b0;
        do_after   = 1'b0;

        n_phase      = r_phase;
        n_dir        = r_dir;
        n_active     = r_active;
        n_cnt        = r_cnt;
        n_timer      = r_timer;
        n_slow       = r_slow;
        n_track      = r_track;
        n_last_force = r_last_force;
        n_last_dist  = r_last_dist;

        res               = '0;
        res.motor_cmd     = CMD_NONE;
        res.speed_cmd     = SPD_KEEP;
        res.goto_position = 32'sd0;

        // Dispatch on the kind of item.
        case (i_mode)
            MODE_START: begin
                if (r_phase == ST_IDLE) begin
                    n_cnt    = 16'd0;
                    do_begin = 1'b1;
                end
            end
            MODE_STOP: begin
                if (r_phase != ST_IDLE) begin
                    n_phase       = ST_IDLE;
                    n_dir         = DIR_STOP;
                    n_cnt         = 16'd0;
                    n_timer       = '0;
                    n_track       = 1'b0;
                    n_slow        = 1'b0;
                    res.motor_cmd = CMD_STOP;
                    res.finished  = 1'b1;
                end
            end
            MODE_FORCE: begin
                n_last_force = i_sample;
                if (r_phase == ST_RUN && by_force) begin
                    do_eval = 1'b1;
                end
            end
            MODE_DIST: begin
                n_last_dist = i_sample;
                if (r_phase == ST_RUN && !by_force) begin
                    do_eval = 1'b1;
                end else if (r_phase == ST_START && r_track) begin
                    if (near_start) begin
                        do_begin   = 1'b1;
                        stop_motor = 1'b1;
                    end
                end else if (r_phase == ST_END && r_track) begin
                    if (near_end) begin
                        n_phase      = ST_IDLE;
                        n_dir        = DIR_STOP;
                        n_track      = 1'b0;
                        n_cnt        = 16'd0;
                        res.finished = 1'b1;
                    end
                end
            end
            MODE_TICK: begin
                if (r_phase == ST_DELAY || r_phase == ST_DWELL) begin
                    if (r_timer <= TIMER_WIDTH'(1)) begin
                        n_timer = '0;
                        if (r_phase == ST_DELAY) begin
                            do_enter = 1'b1;
                        end else begin
                            do_after = 1'b1;
                        end
                    end else begin
                        n_timer = r_timer - TIMER_WIDTH'(1);
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // Start of a load cycle: delay first, or straight into run.
        if (do_begin) begin
            n_track  = 1'b0;
            n_active = i_cfg.target_limit;
            if (!delay_zero) begin
                n_phase = ST_DELAY;
                n_dir   = DIR_STOP;
                n_timer = delay_load;
                if (stop_motor) begin
                    res.motor_cmd = CMD_STOP;
                end
            end else begin
                do_enter = 1'b1;
            end
        end

        // Entering run applies the run rule to the stored sample at once.
        if (do_enter) begin
            n_phase       = ST_RUN;
            n_dir         = DIR_STOP;
            n_slow        = 1'b0;
            n_active      = i_cfg.target_limit;
            res.speed_cmd = SPD_NORMAL;
            do_eval       = 1'b1;
        end

        // Run rule with deadband; a command only on a change of direction.
        if (do_eval) begin
            if (!by_force && !n_slow && in_zone) begin
                n_slow        = 1'b1;
                res.speed_cmd = SPD_REDUCED;
            end
            if (below_band) begin
                if (n_dir != DIR_BACK) begin
                    n_dir         = DIR_BACK;
                    res.motor_cmd = CMD_BACK;
                end
            end else if (above_band) begin
                if (n_dir != DIR_FWD) begin
                    n_dir         = DIR_FWD;
                    res.motor_cmd = CMD_FWD;
                end
            end else begin
                if (!by_force) begin
                    res.speed_cmd = SPD_NORMAL;
                    n_slow        = 1'b0;
                end
                do_reach = 1'b1;
            end
        end

        // Limit reached: dwell, or carry straight on.
        if (do_reach) begin
            if (!dwell_zero) begin
                n_dir         = DIR_STOP;
                res.motor_cmd = CMD_STOP;
                n_phase       = ST_DWELL;
                n_timer       = dwell_load;
            end else begin
                do_after = 1'b1;
            end
        end

        // End of a load cycle: next cycle, end position, or finish.
        if (do_after) begin
            n_dir = DIR_STOP;
            if (last_cycle) begin
                n_cnt = 16'd0;
                if (i_cfg.control_mode[1]) begin
                    n_phase           = ST_END;
                    n_track           = 1'b1;
                    n_active          = i_cfg.end_position;
                    res.motor_cmd     = CMD_GOTO;
                    res.goto_position = i_cfg.end_position;
                end else begin
                    n_phase       = ST_IDLE;
                    n_track       = 1'b0;
                    res.motor_cmd = CMD_STOP;
                    res.finished  = 1'b1;
                end
            end else begin
                n_cnt             = n_cnt + 16'd1;
                n_track           = 1'b1;
                n_phase           = ST_START;
                res.motor_cmd     = CMD_GOTO;
                res.goto_position = i_cfg.start_length;
            end
        end

        res.phase       = n_phase;
        res.cycle_index = n_cnt;
    end

    // The last cycle test sees the counter after any restart by this item.
    always_comb begin
        last_cycle = ({1'b0, r_cnt} + 17'd1) >= {1'b0, i_cfg.cycle_count};
        if (i_mode == MODE_START) begin
            last_cycle = 17'd1 >= {1'b0, i_cfg.cycle_count};
        end
    end

    // State registers, updated once per evaluated item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ST_IDLE;
            r_dir        <= DIR_STOP;
            r_active     <= 32'sd0;
            r_cnt        <= 16'd0;
            r_timer      <= '0;
            r_slow       <= 1'b0;
            r_track      <= 1'b0;
            r_last_force <= 32'sd0;
            r_last_dist  <= 32'sd0;
        end else if (i_valid) begin
            r_phase      <= n_phase;
            r_dir        <= n_dir;
            r_active     <= n_active;
            r_cnt        <= n_cnt;
            r_timer      <= n_timer;
            r_slow       <= n_slow;
            r_track      <= n_track;
            r_last_force <= n_last_force;
            r_last_dist  <= n_last_dist;
        end
    end

    assign o_res = res;

`ifndef NO_ASSERTIONS
    // The hold timer is only live during a delay or a dwell.
    a_timer_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != ST_DELAY && r_phase != ST_DWELL) |-> (r_timer == '0))
        else $error("hold timer nonzero outside a hold");

    // The slow flag only survives while running.
    a_slow_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slow |-> (r_phase == ST_RUN))
        else $error("slow flag set outside run");

    // The stage is never left moving while the sequencer is idle.
    a_idle_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ST_IDLE) |-> (r_dir == DIR_STOP))
        else $error("direction held while idle");
`endif

endmodule

// ----- rtl/core/cyclic_load_step_sequencer.sv -----
// Path: an item moves from its input transfer into the input register, then its evaluation is
// stored in the result register; a stall on the result stream holds it in the input register.
// Throughput: one item per cycle unless the result stream stalls; the whole evaluation is one
// pass of logic between the input and result registers, and state updates as a result is stored.
// Reset: i_rst_n is synchronous and active low; it clears the sequencer state to idle,
// empties both registers and loads the configuration reset values at once.
// Top level of the cyclic load-step sequencer; depends on clss_pkg, clss_cfg, clss_core.
module cyclic_load_step_sequencer
    import clss_pkg::*;
#(
    parameter int SLOW_ZONE_FACTOR = 200,
    parameter int TIMER_WIDTH      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] sample_value
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] mode
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // [2:0] motor_cmd, [4:3] speed_cmd,
                                          // [36:5] goto_position, [39:37] phase,
                                          // [55:40] cycle_index, [56] finished,
                                          // [63:57] zero
);

    t_cfg               cfg;
    t_result            core_res;
    logic               advance;

    logic               r_in_valid;
    logic [2:0]         r_in_mode;
    logic signed [31:0] r_in_sample;
    logic               r_out_valid;
    t_result            r_out;

    clss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    clss_core #(
        .SLOW_ZONE_FACTOR (SLOW_ZONE_FACTOR),
        .TIMER_WIDTH      (TIMER_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (advance),
        .i_mode   (r_in_mode),
        .i_sample (r_in_sample),
        .i_cfg    (cfg),
        .o_res    (core_res)
    );

    // An item moves on when the result register is free or being emptied.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_mode   <= i_s_axis_tuser;
            r_in_sample <= $signed(i_s_axis_tdata);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.finished, r_out.cycle_index, r_out.phase,
                              r_out.goto_position, r_out.speed_cmd, r_out.motor_cmd};

`ifndef NO_ASSERTIONS
    // An evaluated item always lands in the result register.
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("evaluated item did not reach the result register");

    // A finished sequence always reports the idle phase with the counter cleared.
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.finished) |->
            (r_out.phase == PHASE_IDLE && r_out.cycle_index == 16'd0))
        else $error("finished result outside idle");

    // A go-to-position command only comes when heading for start or end.
    a_goto_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.motor_cmd == CMD_GOTO) |->
            (r_out.phase == PHASE_START || r_out.phase == PHASE_END))
        else $error("go-to command in wrong phase");
`endif

endmodule

// ----- test/tb_cyclic_load_step_sequencer.sv -----
// Self-checking testbench for the cyclic load-step sequencer: a directed table, then random
// sequences under several register settings, each result checked against a fixed row or a local predictor.
// Depends on clss_pkg and the cyclic_load_step_sequencer RTL.
module tb_cyclic_load_step_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import clss_pkg::*;

    localparam int SLOW_ZONE         = 200;
    localparam int TIMER_W           = 16;
    localparam int LIMIT_CYCLES      = 400000;
    localparam int RANDOM_SETTINGS   = 10;
    localparam int ITEMS_PER_SETTING = 40;

    // Phase codes that the package does not name.
    localparam logic [2:0] PHASE_DELAY = 3'd1;
    localparam logic [2:0] PHASE_RUN   = 3'd2;
    localparam logic [2:0] PHASE_DWELL = 3'd3;

    // Direction of travel held by the sequencer.
    localparam logic [1:0] DIR_HALT = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    // One row of the directed table: a register write or an input item.
    typedef struct {
        bit          is_write;
        logic [2:0]  code;
        logic [31:0] value;
        bit          typed;
        t_result     want;
    } t_step_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // [31:0] sample_value
    logic [2:0]  i_s_axis_tuser;   // [2:0] mode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [63:0] o_m_axis_tdata;   // [2:0] motor_cmd, [4:3] speed_cmd, [36:5] goto_position,
                                   // [39:37] phase, [55:40] cycle_index, [56] finished

    // Predicted sequencer state and register copy.
    t_cfg               seq_cfg;
    logic [2:0]         seq_phase;
    logic [1:0]         seq_dir;
    longint             seq_target;
    logic [15:0]        seq_cycle;
    logic [TIMER_W-1:0] seq_timer;
    bit                 seq_slow;
    bit                 seq_track;
    longint             seq_force;
    longint             seq_dist;
    t_result            seq_out;

    t_result   expected_results[$];
    t_step_row plan[$];
    int        mismatch_count  = 0;
    int        results_checked = 0;
    int        items_sent      = 0;
    int        writes_done     = 0;
    int        cycle_total     = 0;
    bit        send_burst      = 1'b0;
    bit        take_burst      = 1'b0;

    cyclic_load_step_sequencer #(
        .SLOW_ZONE_FACTOR(SLOW_ZONE),
        .TIMER_WIDTH     (TIMER_W)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always #5ns i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_total++;
        if (cycle_total > LIMIT_CYCLES) begin
            $display("%0t: run timed out with %0d results outstanding", $time,
                     expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(t_step_row r);
        plan.insert(plan.size(), r);
    endfunction

    // Register write as seen by the predictor.
    function automatic void seq_write_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            REG_CONTROL_MODE:  seq_cfg.control_mode  = data[1:0];
            REG_TARGET_LIMIT:  seq_cfg.target_limit  = data;
            REG_START_LENGTH:  seq_cfg.start_length  = data;
            REG_END_POSITION:  seq_cfg.end_position  = data;
            REG_CYCLE_COUNT:   seq_cfg.cycle_count   = data[15:0];
            REG_DISTANCE_BAND: seq_cfg.distance_band = data[15:0];
            REG_FORCE_BAND:    seq_cfg.force_band    = data[15:0];
            default:           seq_cfg.hold_times    = data;
        endcase
    endfunction

    // End of a cycle: return to the start length, go to the end position, or finish the sequence.
    function automatic void seq_after_reach();
        if (int'(seq_cycle) + 1 >= int'(seq_cfg.cycle_count)) begin
            seq_cycle = '0;
            seq_dir   = DIR_HALT;
            if (seq_cfg.control_mode[1]) begin
                seq_phase             = PHASE_END;
                seq_track             = 1'b1;
                seq_target            = longint'($signed(seq_cfg.end_position));
                seq_out.motor_cmd     = CMD_GOTO;
                seq_out.goto_position = seq_cfg.end_position;
            end else begin
                seq_phase         = PHASE_IDLE;
                seq_track         = 1'b0;
                seq_out.motor_cmd = CMD_STOP;
                seq_out.finished  = 1'b1;
            end
        end else begin
            seq_cycle             = seq_cycle + 16'd1;
            seq_track             = 1'b1;
            seq_phase             = PHASE_START;
            seq_dir               = DIR_HALT;
            seq_out.motor_cmd     = CMD_GOTO;
            seq_out.goto_position = seq_cfg.start_length;
        end
    endfunction

    // Limit reached: dwell if a dwell time is set, otherwise end the cycle at once.
    function automatic void seq_reach_limit();
        logic [15:0] dwell;
        dwell = seq_cfg.hold_times[31:16];
        if (dwell != 16'd0) begin
            seq_dir           = DIR_HALT;
            seq_out.motor_cmd = CMD_STOP;
            seq_phase         = PHASE_DWELL;
            seq_timer         = dwell;
        end else begin
            seq_after_reach();
        end
    endfunction

    // Drive toward the limit with a deadband, slowing down near a distance limit.
    function automatic void seq_run_rule();
        bit     by_force;
        longint lim;
        longint v;
        longint band;
        by_force = seq_cfg.control_mode[0];
        lim      = seq_target;
        v        = by_force ? seq_force : seq_dist;
        band     = by_force ? longint'(seq_cfg.force_band) : longint'(seq_cfg.distance_band);
        if (!by_force && !seq_slow && mag(v - lim) < SLOW_ZONE * band) begin
            seq_slow          = 1'b1;
            seq_out.speed_cmd = SPD_REDUCED;
        end
        if (lim - v > band) begin
            if (seq_dir != DIR_BACK) begin
                seq_dir           = DIR_BACK;
                seq_out.motor_cmd = CMD_BACK;
            end
        end else if (v - lim > band) begin
            if (seq_dir != DIR_FWD) begin
                seq_dir           = DIR_FWD;
                seq_out.motor_cmd = CMD_FWD;
            end
        end else begin
            if (!by_force) begin
                seq_out.speed_cmd = SPD_NORMAL;
                seq_slow          = 1'b0;
            end
            seq_reach_limit();
        end
    endfunction

    function automatic void seq_enter_run();
        seq_phase         = PHASE_RUN;
        seq_dir           = DIR_HALT;
        seq_slow          = 1'b0;
        seq_target        = longint'($signed(seq_cfg.target_limit));
        seq_out.speed_cmd = SPD_NORMAL;
        seq_run_rule();
    endfunction

    function automatic void seq_begin_cycle(bit stop_motor);
        logic [15:0] delay;
        delay      = seq_cfg.hold_times[15:0];
        seq_track  = 1'b0;
        seq_target = longint'($signed(seq_cfg.target_limit));
        if (delay != 16'd0) begin
            seq_phase = PHASE_DELAY;
            seq_dir   = DIR_HALT;
            seq_timer = delay;
            if (stop_motor)
                seq_out.motor_cmd = CMD_STOP;
        end else begin
            seq_enter_run();
        end
    endfunction

    // Predicted result of one accepted input item; updates the predicted state.
    function automatic t_result sequencer_predict(logic [2:0] mode, logic [31:0] sample);
        longint value;
        value   = longint'($signed(sample));
        seq_out = '0;
        case (mode)
            MODE_START: begin
                if (seq_phase == PHASE_IDLE) begin
                    seq_cycle = '0;
                    seq_begin_cycle(1'b0);
                end
            end
            MODE_STOP: begin
                if (seq_phase != PHASE_IDLE) begin
                    seq_phase         = PHASE_IDLE;
                    seq_dir           = DIR_HALT;
                    seq_cycle         = '0;
                    seq_timer         = '0;
                    seq_track         = 1'b0;
                    seq_slow          = 1'b0;
                    seq_out.motor_cmd = CMD_STOP;
                    seq_out.finished  = 1'b1;
                end
            end
            MODE_FORCE: begin
                seq_force = value;
                if (seq_phase == PHASE_RUN && seq_cfg.control_mode[0])
                    seq_run_rule();
            end
            MODE_DIST: begin
                seq_dist = value;
                if (seq_phase == PHASE_RUN && !seq_cfg.control_mode[0]) begin
                    seq_run_rule();
                end else if (seq_phase == PHASE_START && seq_track) begin
                    if (2 * mag(longint'($signed(seq_cfg.start_length)) - seq_dist) <
                        longint'(seq_cfg.distance_band))
                        seq_begin_cycle(1'b1);
                end else if (seq_phase == PHASE_END && seq_track) begin
                    if (10 * mag(seq_target - seq_dist) <
                        7 * longint'(seq_cfg.distance_band)) begin
                        seq_phase        = PHASE_IDLE;
                        seq_dir          = DIR_HALT;
                        seq_track        = 1'b0;
                        seq_cycle        = '0;
                        seq_out.finished = 1'b1;
                    end
                end
            end
            MODE_TICK: begin
                if (seq_phase == PHASE_DELAY || seq_phase == PHASE_DWELL) begin
                    if (seq_timer <= 1) begin
                        seq_timer = '0;
                        if (seq_phase == PHASE_DELAY)
                            seq_enter_run();
                        else
                            seq_after_reach();
                    end else begin
                        seq_timer = seq_timer - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        seq_out.phase       = seq_phase;
        seq_out.cycle_index = seq_cycle;
        return seq_out;
    endfunction

    function automatic t_step_row row_item(logic [2:0] mode, logic [31:0] value);
        return '{1'b0, mode, value, 1'b0, '0};
    endfunction

    function automatic t_step_row row_fixed(logic [2:0] mode, logic [31:0] value, t_result want);
        return '{1'b0, mode, value, 1'b1, want};
    endfunction

    function automatic t_step_row row_write(logic [2:0] idx, logic [31:0] value);
        return '{1'b1, idx, value, 1'b0, '0};
    endfunction

    // A sample value near a centre, mostly within a few bands of it.
    function automatic logic [31:0] near_value(longint centre, longint band);
        longint off;
        int     pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       off = 0;
            1, 2, 3: off = $urandom_range(0, int'(band) + 1);
            4, 5:    off = $urandom_range(0, 3 * int'(band) + 3);
            6, 7:    off = $urandom_range(0, SLOW_ZONE * int'(band) + 5);
            default: return $urandom;
        endcase
        if ($urandom_range(0, 1) == 1)
            off = -off;
        return 32'(centre + off);
    endfunction

    // Next random item, shaped by the predicted phase so that sequences run deep.
    function automatic void choose_item(output logic [2:0] mode, output logic [31:0] value);
        int     pick;
        longint band;
        longint dband;
        pick  = $urandom_range(0, 99);
        band  = seq_cfg.control_mode[0] ? longint'(seq_cfg.force_band)
                                        : longint'(seq_cfg.distance_band);
        dband = longint'(seq_cfg.distance_band);
        mode  = MODE_TICK;
        value = $urandom;
        if (pick < 8) begin
            mode = 3'($urandom_range(0, 7));
            return;
        end
        if (pick < 10 && seq_phase != PHASE_IDLE) begin
            mode = MODE_STOP;
            return;
        end
        case (seq_phase)
            PHASE_IDLE: begin
                if (pick < 70) begin
                    mode = MODE_START;
                end else begin
                    mode  = ($urandom_range(0, 1) == 1) ? MODE_FORCE : MODE_DIST;
                    value = near_value(longint'($signed(seq_cfg.target_limit)), band);
                end
            end
            PHASE_DELAY, PHASE_DWELL: begin
                if (pick >= 75) begin
                    mode  = ($urandom_range(0, 1) == 1) ? MODE_FORCE : MODE_DIST;
                    value = near_value(seq_target, band);
                end
            end
            PHASE_RUN: begin
                if (pick < 85)
                    mode = seq_cfg.control_mode[0] ? MODE_FORCE : MODE_DIST;
                else
                    mode = seq_cfg.control_mode[0] ? MODE_DIST : MODE_FORCE;
                value = near_value(seq_target, band);
            end
            PHASE_START: begin
                mode  = (pick < 85) ? MODE_DIST : MODE_FORCE;
                value = near_value(longint'($signed(seq_cfg.start_length)), dband);
            end
            default: begin
                mode  = (pick < 85) ? MODE_DIST : MODE_TICK;
                value = near_value(seq_target, dband);
            end
        endcase
    endfunction

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // One result transfer against the oldest expectation.
    function automatic void check_result(logic [63:0] word);
        t_result want;
        results_checked++;
        if (expected_results.size() == 0) begin
            $display("%0t: result %h arrived with no expectation waiting", $time, word);
            mismatch_count++;
        end else begin
            want = expected_results.pop_front();
            compare_field("motor_cmd", want.motor_cmd, word[2:0]);
            compare_field("speed_cmd", want.speed_cmd, word[4:3]);
            compare_field("goto_position", longint'($signed(want.goto_position)),
                          longint'($signed(word[36:5])));
            compare_field("phase", want.phase, word[39:37]);
            compare_field("cycle_index", want.cycle_index, word[55:40]);
            compare_field("finished", want.finished, word[56]);
            compare_field("padding", 0, word[63:57]);
        end
    endfunction

    // Input transfer after a random gap (none in a burst); the expectation is queued on acceptance.
    task automatic send_item(input logic [2:0] mode, input logic [31:0] value,
                             input bit typed, input t_result want);
        int      gap;
        t_result predicted;
        gap = send_burst ? 0 : $urandom_range(0, 17);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= mode;
        i_s_axis_tdata  <= value;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = sequencer_predict(mode, value);
        expected_results.insert(expected_results.size(), typed ? want : predicted);
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        seq_write_reg(idx, value);
        writes_done++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every expected result has arrived and the pipeline has drained.
    task automatic settle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Result side: random stall before each transfer, with stretches of none.
    initial begin
        int stall;
        i_m_axis_tready = 1'b0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 24) == 0)
                take_burst = !take_burst;
            stall = take_burst ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            check_result(o_m_axis_tdata);
        end
    end

    // Stimulus: directed table first, then random sequences per register setting.
    initial begin
        t_result     ignored_idle;
        t_result     stopped;
        t_result     end_reached;
        t_result     none;
        t_step_row   row;
        logic [31:0] regs [8];
        logic [2:0]  mode;
        logic [31:0] value;
        bit          prev_write;
        int          done;
        int          directed_items;

        ignored_idle = '{CMD_NONE, SPD_KEEP, 32'sd0, PHASE_IDLE, 16'd0, 1'b0};
        stopped      = '{CMD_STOP, SPD_KEEP, 32'sd0, PHASE_IDLE, 16'd0, 1'b1};
        end_reached  = '{CMD_NONE, SPD_KEEP, 32'sd0, PHASE_IDLE, 16'd0, 1'b1};
        none         = '0;

        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;

        seq_cfg               = '0;
        seq_cfg.cycle_count   = 16'd1;
        seq_phase             = PHASE_IDLE;
        seq_dir               = DIR_HALT;
        seq_target            = 0;
        seq_cycle             = '0;
        seq_timer             = '0;
        seq_slow              = 1'b0;
        seq_track             = 1'b0;
        seq_force             = 0;
        seq_dist              = 0;

        // Idle: ticks, stops, unused modes and samples change nothing visible.
        add_row(row_fixed(MODE_TICK, 32'h0000_0000, ignored_idle));
        add_row(row_fixed(MODE_STOP, 32'hFFFF_FFFF, ignored_idle));
        add_row(row_fixed(3'd5, 32'h1234_5678, ignored_idle));
        add_row(row_fixed(3'd7, 32'hFFFF_FFFF, ignored_idle));
        add_row(row_fixed(MODE_FORCE, 32'h7FFF_FFFF, ignored_idle));
        add_row(row_fixed(MODE_DIST, 32'h8000_0000, ignored_idle));
        // Distance run over repeated load cycles with delay and dwell.
        add_row(row_write(REG_CONTROL_MODE, 32'd0));
        add_row(row_write(REG_TARGET_LIMIT, 32'd1000));
        add_row(row_write(REG_START_LENGTH, 32'd0));
        add_row(row_write(REG_END_POSITION, 32'd5000));
        add_row(row_write(REG_CYCLE_COUNT, 32'd2));
        add_row(row_write(REG_DISTANCE_BAND, 32'd10));
        add_row(row_write(REG_FORCE_BAND, 32'd0));
        add_row(row_write(REG_HOLD_TIMES, 32'h0001_0002));
        add_row(row_item(MODE_START, 32'd0));
        add_row(row_item(MODE_START, 32'd0));
        add_row(row_item(MODE_DIST, 32'd0));
        add_row(row_item(MODE_TICK, 32'd0));
        add_row(row_item(MODE_TICK, 32'd0));
        add_row(row_item(MODE_DIST, 32'd500));
        add_row(row_item(MODE_DIST, 32'd1000));
        add_row(row_item(MODE_TICK, 32'd0));
        add_row(row_item(MODE_DIST, 32'd3));
        add_row(row_fixed(MODE_STOP, 32'd0, stopped));
        // Force limit at the extremes, then the move to the end position.
        add_row(row_write(REG_CONTROL_MODE, 32'd3));
        add_row(row_write(REG_TARGET_LIMIT, 32'h8000_0000));
        add_row(row_write(REG_START_LENGTH, 32'h7FFF_FFFF));
        add_row(row_write(REG_END_POSITION, 32'h7FFF_FFFF));
        add_row(row_write(REG_CYCLE_COUNT, 32'd1));
        add_row(row_write(REG_DISTANCE_BAND, 32'h0000_FFFF));
        add_row(row_write(REG_FORCE_BAND, 32'h0000_FFFF));
        add_row(row_write(REG_HOLD_TIMES, 32'd0));
        add_row(row_fixed(MODE_FORCE, 32'd0, ignored_idle));
        add_row(row_item(MODE_START, 32'd0));
        add_row(row_item(MODE_FORCE, 32'h8000_0000));
        add_row(row_fixed(MODE_DIST, 32'h7FFF_FFFF, end_reached));
        // A zero cycle count behaves as one; then the longest holds, cut short by stop.
        add_row(row_write(REG_CONTROL_MODE, 32'd0));
        add_row(row_write(REG_CYCLE_COUNT, 32'd0));
        add_row(row_write(REG_TARGET_LIMIT, 32'd0));
        add_row(row_write(REG_DISTANCE_BAND, 32'd0));
        add_row(row_item(MODE_START, 32'd0));
        add_row(row_item(MODE_DIST, 32'd0));
        add_row(row_write(REG_HOLD_TIMES, 32'hFFFF_FFFF));
        add_row(row_item(MODE_START, 32'd0));
        add_row(row_item(MODE_TICK, 32'd0));
        add_row(row_fixed(MODE_STOP, 32'd0, stopped));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; writes only once the block has drained.
        prev_write = 1'b0;
        foreach (plan[k]) begin
            row = plan[k];
            if (row.is_write) begin
                if (!prev_write)
                    settle();
                write_reg(row.code, row.value);
            end else begin
                send_item(row.code, row.value, row.typed, row.want);
            end
            prev_write = row.is_write;
        end
        directed_items = items_sent;

        // Random part: one register setting per pass, the first two at the extremes.
        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            send_burst = 1'b0;
            if (seq_phase != PHASE_IDLE)
                send_item(MODE_STOP, $urandom, 1'b0, none);
            settle();
            if (s == 0) begin
                regs = '{32'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                         32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'd0};
            end else if (s == 1) begin
                regs = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0,
                         32'd1, 32'd0, 32'd0, 32'h0001_0001};
            end else begin
                regs[REG_CONTROL_MODE]  = $urandom_range(0, 3);
                regs[REG_TARGET_LIMIT]  = ($urandom_range(0, 4) == 0) ? $urandom
                                          : 32'($urandom_range(0, 4000)) - 32'd2000;
                regs[REG_START_LENGTH]  = ($urandom_range(0, 4) == 0) ? $urandom
                                          : 32'($urandom_range(0, 4000)) - 32'd2000;
                regs[REG_END_POSITION]  = ($urandom_range(0, 4) == 0) ? $urandom
                                          : 32'($urandom_range(0, 4000)) - 32'd2000;
                regs[REG_CYCLE_COUNT]   = ($urandom_range(0, 9) == 0) ? 32'h0000_FFFF
                                          : $urandom_range(1, 4);
                regs[REG_DISTANCE_BAND] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(1, 60);
                regs[REG_FORCE_BAND]    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, 60);
                regs[REG_HOLD_TIMES]    = ($urandom_range(0, 9) == 0) ? $urandom
                                          : {16'($urandom_range(0, 3)),
                                             16'($urandom_range(0, 3))};
            end
            for (int idx = 0; idx < 8; idx++)
                write_reg(3'(idx), regs[idx]);
            send_burst = ($urandom_range(0, 3) == 0);
            done = 0;
            while (done < ITEMS_PER_SETTING) begin
                choose_item(mode, value);
                // Only items that the sequencer acts on or stores count.
                if (mode == MODE_FORCE || mode == MODE_DIST ||
                    (mode == MODE_START && seq_phase == PHASE_IDLE) ||
                    (mode == MODE_STOP && seq_phase != PHASE_IDLE) ||
                    (mode == MODE_TICK &&
                     (seq_phase == PHASE_DELAY || seq_phase == PHASE_DWELL)))
                    done++;
                if ($urandom_range(0, 19) == 0)
                    send_burst = !send_burst;
                send_item(mode, value, 1'b0, none);
            end
        end

        settle();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d input items (%0d from the directed table) across %0d register writes.",
                 items_sent, directed_items, writes_done);
        $display("Compared %0d results field by field; %0d mismatches found.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
